FILE: rtl/ece_pkg.sv
package ece_pkg;

    localparam int FRAC_BITS_DEF        = 15;
    localparam int SINE_TABLE_DEPTH_DEF = 256;

    localparam int          Q30_SHIFT = 30;
    localparam longint      PIH_Q30   = 64'sd1686629713;

    localparam int CURVE_MODE_W = 4;
    localparam int FIELD_W      = 16;

    localparam logic [CURVE_MODE_W-1:0] MODE_IO_SINE   = 4'd3;
    localparam logic [CURVE_MODE_W-1:0] MODE_IO_QUAD   = 4'd4;
    localparam logic [CURVE_MODE_W-1:0] MODE_IO_CUBIC  = 4'd5;
    localparam logic [CURVE_MODE_W-1:0] MODE_IO_QUART  = 4'd6;
    localparam logic [CURVE_MODE_W-1:0] MODE_IN_SINE   = 4'd7;
    localparam logic [CURVE_MODE_W-1:0] MODE_IN_QUAD   = 4'd8;
    localparam logic [CURVE_MODE_W-1:0] MODE_IN_CUBIC  = 4'd9;
    localparam logic [CURVE_MODE_W-1:0] MODE_IN_QUART  = 4'd10;
    localparam logic [CURVE_MODE_W-1:0] MODE_OUT_SINE  = 4'd11;
    localparam logic [CURVE_MODE_W-1:0] MODE_OUT_QUAD  = 4'd12;
    localparam logic [CURVE_MODE_W-1:0] MODE_OUT_CUBIC = 4'd13;
    localparam logic [CURVE_MODE_W-1:0] MODE_OUT_QUART = 4'd14;

    typedef enum logic [1:0] {
        DIR_IN   = 2'd0,
        DIR_OUT  = 2'd1,
        DIR_BOTH = 2'd2
    } t_dir;

    typedef struct packed {
        logic       sine;
        t_dir       dir;
        logic       hi;
        logic [2:0] n;
    } t_ctl;

endpackage

FILE: rtl/ece_sinq.sv
module ece_sinq
    import ece_pkg::*;
#(
    parameter int FRAC_BITS        = FRAC_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en_a,
    input  logic                 i_en_b,
    input  logic [FRAC_BITS:0]   i_p,
    output logic [FRAC_BITS:0]   o_sin
);

    localparam int W1  = FRAC_BITS + 1;
    localparam int IW  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int TIW = $clog2(SINE_TABLE_DEPTH);
    localparam int PW  = W1 + IW;
    localparam int XW  = PW - FRAC_BITS;
    localparam int MW  = W1 + FRAC_BITS + 2;
    localparam logic [W1-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [MW-1:0] HALF_S = MW'(1) << (FRAC_BITS - 1);
    localparam longint ONE_L     = longint'(1) <<< FRAC_BITS;
    localparam longint DEPTH_L   = longint'(SINE_TABLE_DEPTH);
    localparam longint DEPTH_RND = longint'(SINE_TABLE_DEPTH / 2);

    // sin(pi/2 * k / depth), taylor series through the 13th power
    function automatic longint sine_entry(input int k);
        longint th, th2, term, acc, val;
        th   = (PIH_Q30 * longint'(k) + DEPTH_RND) / DEPTH_L;
        th2  = (th * th) >>> Q30_SHIFT;
        term = th;
        acc  = th;
        term = ((term * th2) >>> Q30_SHIFT) / 64'sd6;
        acc  = acc - term;
        term = ((term * th2) >>> Q30_SHIFT) / 64'sd20;
        acc  = acc + term;
        term = ((term * th2) >>> Q30_SHIFT) / 64'sd42;
        acc  = acc - term;
        term = ((term * th2) >>> Q30_SHIFT) / 64'sd72;
        acc  = acc + term;
        term = ((term * th2) >>> Q30_SHIFT) / 64'sd110;
        acc  = acc - term;
        term = ((term * th2) >>> Q30_SHIFT) / 64'sd156;
        acc  = acc + term;
        if (Q30_SHIFT - FRAC_BITS > 0) begin
            val = (acc + (longint'(1) <<< (Q30_SHIFT - FRAC_BITS - 1)))
                  >>> (Q30_SHIFT - FRAC_BITS);
        end else begin
            val = acc;
        end
        if (val < 0) begin
            val = 0;
        end
        if (val > ONE_L) begin
            val = ONE_L;
        end
        if (k == 0) begin
            val = 0;
        end
        if (k == SINE_TABLE_DEPTH) begin
            val = ONE_L;
        end
        return val;
    endfunction

    logic [2*W1-1:0]      w_tab [SINE_TABLE_DEPTH];
    logic [PW-1:0]        w_pos;
    logic [XW-1:0]        w_idx;
    logic [2*W1-1:0]      w_pair;
    logic [W1-1:0]        n_lo, n_hi;
    logic [W1-1:0]        r_lo, r_hi;
    logic [FRAC_BITS-1:0] r_frac;
    logic signed [W1:0]   w_diff;
    logic signed [MW-1:0] w_prod, w_rnd;
    logic signed [W1:0]   w_sum;
    logic [W1-1:0]        r_sin;

    // neighboring table entries side by side
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_tab
        localparam logic [W1-1:0] LO = W1'(sine_entry(k));
        localparam logic [W1-1:0] HI = W1'(sine_entry(k + 1));
        assign w_tab[k] = {HI, LO};
    end

    // table position and lookup
    always_comb begin
        w_pos  = PW'(i_p) * PW'(SINE_TABLE_DEPTH);
        w_idx  = w_pos[PW-1:FRAC_BITS];
        w_pair = w_tab[w_idx[TIW-1:0]];
        if (w_idx >= XW'(SINE_TABLE_DEPTH)) begin
            n_lo = ONE;
            n_hi = ONE;
        end else begin
            n_lo = w_pair[W1-1:0];
            n_hi = w_pair[2*W1-1:W1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_frac <= w_pos[FRAC_BITS-1:0];
        end
    end

    // linear interpolation
    always_comb begin
        w_diff = $signed({1'b0, r_hi}) - $signed({1'b0, r_lo});
        w_prod = MW'(w_diff) * $signed(MW'({1'b0, r_frac}));
        w_rnd  = (w_prod + HALF_S) >>> FRAC_BITS;
        w_sum  = $signed({1'b0, r_lo}) + w_rnd[W1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_sin <= w_sum[W1-1:0];
        end
    end

    assign o_sin = r_sin;

endmodule

FILE: rtl/easing_curve_evaluator_core.sv
// Easing curve evaluator: one eased value y per position x, both unsigned
// Q1.FRAC_BITS with 1.0 at 2^FRAC_BITS (32768 by default); x above 1.0 is
// clamped and y saturates to [0, 1.0]. curve_mode picks sine, quad, cubic or
// quartic as in-out (3..6), in (7..10) or out (11..14); other codes pass x
// through. Sine uses a quarter-wave table with linear interpolation. The
// datapath is five register stages (argument, square or table read, cube or
// interpolation, fourth power, final combine), so one request is taken every
// clock while the output is not stalled; empty stages close up under
// back-pressure. Write curve_mode only while no request is in flight.
module easing_curve_evaluator_core
    import ece_pkg::*;
#(
    parameter int FRAC_BITS        = FRAC_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [FIELD_W-1:0]      i_x_position,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [FIELD_W-1:0]      o_eased_value,
    input  logic                    i_curve_mode_we,
    input  logic [CURVE_MODE_W-1:0] i_curve_mode
);

    localparam int W1 = FRAC_BITS + 1;
    localparam int XE = W1 + FIELD_W;
    localparam logic [W1-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [W1-1:0] HALF = W1'(1) << (FRAC_BITS - 1);

    function automatic logic [W1-1:0] mulq(input logic [W1-1:0] a,
                                           input logic [W1-1:0] b);
        logic [2*W1-1:0] pr;
        pr = (2*W1)'(a) * (2*W1)'(b);
        pr = pr + (2*W1)'(HALF);
        return W1'(pr >> FRAC_BITS);
    endfunction

    logic [CURVE_MODE_W-1:0] r_mode;
    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    logic [XE-1:0]  w_xe;
    logic [W1-1:0]  w_x;
    logic [W1:0]    w_two_x;
    t_ctl           n_ctl;
    logic [W1-1:0]  n_arg;

    t_ctl           r1_ctl, r2_ctl, r3_ctl, r4_ctl;
    logic [W1-1:0]  r1_arg, r2_arg, r3_arg;
    logic [W1-1:0]  r2_m, r3_m, r4_val;
    logic [W1-1:0]  w_sin;
    logic [W1:0]    w_ve, w_onee, n_y;
    logic [W1-1:0]  r5_y;
    logic [XE-1:0]  w_ye;

    // stall chain, bubbles close up
    assign w_en5      = !r_vld5 || i_out_ready;
    assign w_en4      = !r_vld4 || w_en5;
    assign w_en3      = !r_vld3 || w_en4;
    assign w_en2      = !r_vld2 || w_en3;
    assign w_en1      = !r_vld1 || w_en2;
    assign o_in_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (i_curve_mode_we) begin
                r_mode <= i_curve_mode;
            end
            if (w_en1) r_vld1 <= i_in_valid;
            if (w_en2) r_vld2 <= r_vld1;
            if (w_en3) r_vld3 <= r_vld2;
            if (w_en4) r_vld4 <= r_vld3;
            if (w_en5) r_vld5 <= r_vld4;
        end
    end

    // stage 1: clamp, decode, curve argument
    always_comb begin
        w_xe    = XE'(i_x_position);
        w_x     = (w_xe > XE'(ONE)) ? ONE : w_xe[W1-1:0];
        w_two_x = {w_x, 1'b0};
        n_ctl   = '{sine: 1'b0, dir: DIR_IN, hi: 1'b0, n: 3'd1};
        unique case (r_mode)
            MODE_IO_SINE: begin
                n_ctl.sine = 1'b1;
                n_ctl.dir  = DIR_BOTH;
            end
            MODE_IN_SINE: begin
                n_ctl.sine = 1'b1;
                n_ctl.dir  = DIR_IN;
            end
            MODE_OUT_SINE: begin
                n_ctl.sine = 1'b1;
                n_ctl.dir  = DIR_OUT;
            end
            MODE_IO_QUAD, MODE_IO_CUBIC, MODE_IO_QUART: begin
                n_ctl.dir = DIR_BOTH;
                n_ctl.n   = 3'(r_mode - MODE_IO_QUAD) + 3'd2;
            end
            MODE_IN_QUAD, MODE_IN_CUBIC, MODE_IN_QUART: begin
                n_ctl.dir = DIR_IN;
                n_ctl.n   = 3'(r_mode - MODE_IN_QUAD) + 3'd2;
            end
            MODE_OUT_QUAD, MODE_OUT_CUBIC, MODE_OUT_QUART: begin
                n_ctl.dir = DIR_OUT;
                n_ctl.n   = 3'(r_mode - MODE_OUT_QUAD) + 3'd2;
            end
            default: begin
                n_ctl.dir = DIR_IN;
            end
        endcase
        n_arg = w_x;
        if (n_ctl.sine) begin
            unique case (n_ctl.dir)
                DIR_IN:   n_arg = ONE - w_x;
                DIR_OUT:  n_arg = w_x;
                DIR_BOTH: begin
                    n_ctl.hi = (w_x > HALF);
                    n_arg    = n_ctl.hi ? W1'(w_two_x - (W1+1)'(ONE))
                                        : W1'((W1+1)'(ONE) - w_two_x);
                end
                default:  n_arg = w_x;
            endcase
        end else begin
            unique case (n_ctl.dir)
                DIR_IN:   n_arg = w_x;
                DIR_OUT:  n_arg = ONE - w_x;
                DIR_BOTH: begin
                    n_ctl.hi = (w_x >= HALF);
                    n_arg    = n_ctl.hi ? W1'({ONE, 1'b0} - w_two_x) : W1'(w_two_x);
                end
                default:  n_arg = w_x;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_ctl <= n_ctl;
            r1_arg <= n_arg;
        end
        if (w_en2) begin
            r2_ctl <= r1_ctl;
            r2_arg <= r1_arg;
            r2_m   <= (r1_ctl.n >= 3'd2) ? mulq(r1_arg, r1_arg) : r1_arg;
        end
        if (w_en3) begin
            r3_ctl <= r2_ctl;
            r3_arg <= r2_arg;
            r3_m   <= (r2_ctl.n >= 3'd3) ? mulq(r2_m, r2_arg) : r2_m;
        end
        if (w_en4) begin
            r4_ctl <= r3_ctl;
            if (r3_ctl.sine) begin
                r4_val <= w_sin;
            end else begin
                r4_val <= (r3_ctl.n >= 3'd4) ? mulq(r3_m, r3_arg) : r3_m;
            end
        end
        if (w_en5) begin
            r5_y <= n_y[W1-1:0];
        end
    end

    ece_sinq #(
        .FRAC_BITS        (FRAC_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sinq (
        .i_clk  (i_clk),
        .i_en_a (w_en2),
        .i_en_b (w_en3),
        .i_p    (r1_arg),
        .o_sin  (w_sin)
    );

    // stage 5: fold back, halve, saturate
    always_comb begin
        w_ve   = (W1+1)'(r4_val);
        w_onee = (W1+1)'(ONE);
        n_y    = w_ve;
        if (r4_ctl.sine) begin
            unique case (r4_ctl.dir)
                DIR_IN:   n_y = w_onee - w_ve;
                DIR_OUT:  n_y = w_ve;
                DIR_BOTH: n_y = r4_ctl.hi ? ((w_onee + w_ve + 1'b1) >> 1)
                                          : ((w_onee - w_ve + 1'b1) >> 1);
                default:  n_y = w_ve;
            endcase
        end else begin
            unique case (r4_ctl.dir)
                DIR_IN:   n_y = w_ve;
                DIR_OUT:  n_y = w_onee - w_ve;
                DIR_BOTH: n_y = r4_ctl.hi ? (w_onee - ((w_ve + 1'b1) >> 1))
                                          : ((w_ve + 1'b1) >> 1);
                default:  n_y = w_ve;
            endcase
        end
        if (n_y > w_onee) begin
            n_y = w_onee;
        end
    end

    assign w_ye          = XE'(r5_y);
    assign o_eased_value = w_ye[FIELD_W-1:0];
    assign o_out_valid   = r_vld5;

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld5 |-> (r5_y <= ONE))
        else $error("eased value above one");

    a_request_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld1)
        else $error("accepted request not in first stage");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_vld1 && r_vld2 && r_vld3 && r_vld4 && r_vld5))
        else $error("input stalled with an empty stage");

endmodule

FILE: verif/easing_curve_evaluator_core_tb.sv
`timescale 1ns / 100ps

module easing_curve_evaluator_core_tb;
    import ece_pkg::*;

    localparam longint ONE_Q   = longint'(1) << FRAC_BITS_DEF;
    localparam longint HALF_Q  = longint'(1) << (FRAC_BITS_DEF - 1);
    localparam int     TAB_LEN = SINE_TABLE_DEPTH_DEF;

    // codes that fall through to the linear curve
    localparam logic [CURVE_MODE_W-1:0] MODE_LINEAR   = 4'd0;
    localparam logic [CURVE_MODE_W-1:0] MODE_LINEAR_1 = 4'd1;
    localparam logic [CURVE_MODE_W-1:0] MODE_LINEAR_2 = 4'd2;
    localparam logic [CURVE_MODE_W-1:0] MODE_LINEAR_F = 4'd15;

    localparam int PHASE_SEGMENTS = 29;
    localparam int SEGMENT_ITEMS  = 50;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [CURVE_MODE_W-1:0] mode;
        logic [FIELD_W-1:0]      x;
        logic                    has_y;
        logic [FIELD_W-1:0]      y;
    } t_vector;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [FIELD_W-1:0]      i_x_position;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [FIELD_W-1:0]      o_eased_value;
    logic                    i_curve_mode_we;
    logic [CURVE_MODE_W-1:0] i_curve_mode;

    longint                  sine_tab [0:TAB_LEN];
    logic [CURVE_MODE_W-1:0] cur_mode;
    logic [FIELD_W-1:0]      expected_eased [$];
    t_vector                 vectors [$];
    int                      send_idle_pct = 0;
    int                      recv_idle_pct = 0;
    int                      error_count   = 0;

    easing_curve_evaluator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_x_position    (i_x_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_eased_value   (o_eased_value),
        .i_curve_mode_we (i_curve_mode_we),
        .i_curve_mode    (i_curve_mode)
    );

    function automatic void build_sine_table();
        longint th, th2, term, acc, v;
        for (int k = 0; k <= TAB_LEN; k++) begin
            th   = (PIH_Q30 * k + TAB_LEN / 2) / TAB_LEN;
            th2  = (th * th) >>> Q30_SHIFT;
            term = th;
            acc  = th;
            for (int n = 1; n <= 6; n++) begin
                term = (term * th2) >>> Q30_SHIFT;
                term = term / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            v = (acc + (longint'(1) << (Q30_SHIFT - FRAC_BITS_DEF - 1)))
                >>> (Q30_SHIFT - FRAC_BITS_DEF);
            if (v < 0) v = 0;
            if (v > ONE_Q) v = ONE_Q;
            sine_tab[k] = v;
        end
        sine_tab[0]       = 0;
        sine_tab[TAB_LEN] = ONE_Q;
    endfunction

    function automatic void add_row(input logic [CURVE_MODE_W-1:0] mode,
                                    input logic [FIELD_W-1:0] x, input logic has_y,
                                    input logic [FIELD_W-1:0] y);
        t_vector row;
        row.mode  = mode;
        row.x     = x;
        row.has_y = has_y;
        row.y     = y;
        vectors.insert(vectors.size(), row);
    endfunction

    function automatic void add_expected(input logic [FIELD_W-1:0] y);
        expected_eased.insert(expected_eased.size(), y);
    endfunction

    function automatic longint q_mul(longint a, longint b);
        return (a * b + HALF_Q) >>> FRAC_BITS_DEF;
    endfunction

    function automatic longint q_half(longint v);
        return (v + 1) >>> 1;
    endfunction

    function automatic longint q_pow(longint a, int n);
        longint r;
        r = a;
        for (int i = 1; i < n; i++) r = q_mul(r, a);
        return r;
    endfunction

    // sin(pi/2 * p), quarter-wave table with linear interpolation
    function automatic longint sine_quarter(longint p);
        longint pos, idx, frac, lo, hi;
        if (p < 0) p = 0;
        if (p > ONE_Q) p = ONE_Q;
        pos  = p * TAB_LEN;
        idx  = pos >>> FRAC_BITS_DEF;
        frac = pos & (ONE_Q - 1);
        if (idx >= TAB_LEN) return sine_tab[TAB_LEN];
        lo = sine_tab[idx];
        hi = sine_tab[idx + 1];
        return lo + (((hi - lo) * frac + HALF_Q) >>> FRAC_BITS_DEF);
    endfunction

    function automatic longint pow_in_out(longint x, int n);
        if (x < HALF_Q) return q_half(q_pow(2 * x, n));
        return ONE_Q - q_half(q_pow(2 * ONE_Q - 2 * x, n));
    endfunction

    function automatic logic [FIELD_W-1:0] eased_curve(logic [CURVE_MODE_W-1:0] mode,
                                                       logic [FIELD_W-1:0] x_in);
        longint x, y;
        x = x_in;
        if (x > ONE_Q) x = ONE_Q;
        case (mode)
            MODE_IN_SINE:   y = ONE_Q - sine_quarter(ONE_Q - x);
            MODE_OUT_SINE:  y = sine_quarter(x);
            MODE_IO_SINE: begin
                if (x <= HALF_Q) begin
                    y = q_half(ONE_Q - sine_quarter(ONE_Q - 2 * x));
                end else begin
                    y = q_half(ONE_Q + sine_quarter(2 * x - ONE_Q));
                end
            end
            MODE_IN_QUAD:   y = q_pow(x, 2);
            MODE_IN_CUBIC:  y = q_pow(x, 3);
            MODE_IN_QUART:  y = q_pow(x, 4);
            MODE_OUT_QUAD:  y = ONE_Q - q_pow(ONE_Q - x, 2);
            MODE_OUT_CUBIC: y = ONE_Q - q_pow(ONE_Q - x, 3);
            MODE_OUT_QUART: y = ONE_Q - q_pow(ONE_Q - x, 4);
            MODE_IO_QUAD:   y = pow_in_out(x, 2);
            MODE_IO_CUBIC:  y = pow_in_out(x, 3);
            MODE_IO_QUART:  y = pow_in_out(x, 4);
            default:        y = x;
        endcase
        if (y < 0) y = 0;
        if (y > ONE_Q) y = ONE_Q;
        return y[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] random_position();
        logic [FIELD_W-1:0] x;
        case ($urandom_range(9))
            6:       x = FIELD_W'($urandom_range(65535));
            7: begin
                case ($urandom_range(3))
                    0:       x = 0;
                    1:       x = 1;
                    2:       x = 32767;
                    default: x = 65535;
                endcase
            end
            8:       x = FIELD_W'($urandom_range(HALF_Q + 8, HALF_Q - 8));
            9:       x = FIELD_W'($urandom_range(ONE_Q, ONE_Q - 8));
            default: x = FIELD_W'($urandom_range(ONE_Q));
        endcase
        return x;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_position(input logic [FIELD_W-1:0] x, input logic has_y,
                                 input logic [FIELD_W-1:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_x_position <= x;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        add_expected(has_y ? y : eased_curve(cur_mode, x));
        @(negedge i_clk);
    endtask

    // write the mode only with the pipeline empty
    task automatic set_mode(input logic [CURVE_MODE_W-1:0] mode);
        i_in_valid <= 1'b0;
        while (expected_eased.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_curve_mode_we <= 1'b1;
        i_curve_mode    <= mode;
        @(negedge i_clk);
        i_curve_mode_we <= 1'b0;
        cur_mode = mode;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_eased.size() == 0) begin
                $display("%0t: unexpected result, actual %0d", $time, o_eased_value);
                error_count++;
            end else begin
                if (o_eased_value !== expected_eased[0]) begin
                    $display("%0t: eased_value mismatch, expected %0d actual %0d",
                             $time, expected_eased[0], o_eased_value);
                    error_count++;
                end
                void'(expected_eased.pop_front());
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_x_position    = '0;
        i_out_ready     = 1'b0;
        i_curve_mode_we = 1'b0;
        i_curve_mode    = MODE_LINEAR;
        cur_mode        = MODE_LINEAR;
        build_sine_table();

        add_row(MODE_LINEAR,    16'd0,     1'b1, 16'd0);
        add_row(MODE_LINEAR,    16'd32768, 1'b1, 16'd32768);
        add_row(MODE_LINEAR,    16'hffff,  1'b1, 16'd32768);
        add_row(MODE_LINEAR,    16'h5555,  1'b1, 16'h5555);
        add_row(MODE_LINEAR_F,  16'h2aaa,  1'b1, 16'h2aaa);
        add_row(MODE_LINEAR_1,  16'h7fff,  1'b1, 16'h7fff);
        add_row(MODE_LINEAR_2,  16'hffff,  1'b1, 16'd32768);
        add_row(MODE_IO_SINE,   16'd0,     1'b1, 16'd0);
        add_row(MODE_IO_SINE,   16'd16384, 1'b0, 16'd0);
        add_row(MODE_IO_SINE,   16'd16385, 1'b0, 16'd0);
        add_row(MODE_IO_QUAD,   16'd16383, 1'b0, 16'd0);
        add_row(MODE_IO_QUAD,   16'd16384, 1'b0, 16'd0);
        add_row(MODE_IO_CUBIC,  16'd32768, 1'b1, 16'd32768);
        add_row(MODE_IO_QUART,  16'd0,     1'b1, 16'd0);
        add_row(MODE_IO_QUART,  16'd40000, 1'b1, 16'd32768);
        add_row(MODE_IN_SINE,   16'd0,     1'b1, 16'd0);
        add_row(MODE_IN_SINE,   16'd32768, 1'b1, 16'd32768);
        add_row(MODE_IN_QUAD,   16'd12345, 1'b0, 16'd0);
        add_row(MODE_IN_CUBIC,  16'hffff,  1'b1, 16'd32768);
        add_row(MODE_IN_QUART,  16'd1,     1'b0, 16'd0);
        add_row(MODE_OUT_SINE,  16'd0,     1'b1, 16'd0);
        add_row(MODE_OUT_SINE,  16'd32768, 1'b1, 16'd32768);
        add_row(MODE_OUT_QUAD,  16'd0,     1'b1, 16'd0);
        add_row(MODE_OUT_CUBIC, 16'd32768, 1'b1, 16'd32768);
        add_row(MODE_OUT_QUART, 16'd20000, 1'b0, 16'd0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (vectors[i]) begin
            if (vectors[i].mode != cur_mode) set_mode(vectors[i].mode);
            send_position(vectors[i].x, vectors[i].has_y, vectors[i].y);
        end

        for (int s = 0; s < PHASE_SEGMENTS; s++) begin
            if (s < 10) begin
                send_idle_pct = 36;
                recv_idle_pct = 86;
            end else if (s < 20) begin
                send_idle_pct = 86;
                recv_idle_pct = 36;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (s < 16) begin
                set_mode(CURVE_MODE_W'((s * 7) % 16));
            end else begin
                set_mode(CURVE_MODE_W'($urandom_range(15)));
            end
            for (int j = 0; j < SEGMENT_ITEMS; j++) begin
                send_position(random_position(), 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (expected_eased.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ece_pkg.sv
rtl/ece_sinq.sv
rtl/easing_curve_evaluator_core.sv
verif/easing_curve_evaluator_core_tb.sv
